### hw/rtl/tcc_pkg.sv
`timescale 1ns / 1ps

package tcc_pkg;

   // field widths of the transaction payloads
   localparam int MODE_W       = 1;
   localparam int CHAR_W       = 8;
   localparam int READ_ROW_W   = 5;
   localparam int READ_COL_W   = 7;
   localparam int CURSOR_COL_W = 7;
   localparam int CURSOR_ROW_W = 5;

   // default screen geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'h0D;

   // request modes
   localparam logic [MODE_W-1:0] MODE_PUT  = 1'b0;
   localparam logic [MODE_W-1:0] MODE_READ = 1'b1;

endpackage

### hw/rtl/tcc_if.sv
`timescale 1ns / 1ps

// request channel: one console operation
interface tcc_req_if import tcc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [CHAR_W-1:0]     char_code;
   logic [READ_ROW_W-1:0] read_row;
   logic [READ_COL_W-1:0] read_col;

   modport source (output valid, mode, char_code, read_row, read_col, input ready);
   modport sink   (input valid, mode, char_code, read_row, read_col, output ready);
endinterface

// response channel: cell and cursor after each operation
interface tcc_rsp_if import tcc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CHAR_W-1:0]       cell_char;
   logic [CURSOR_COL_W-1:0] cursor_col;
   logic [CURSOR_ROW_W-1:0] cursor_row;
   logic                    scrolled;

   modport source (output valid, cell_char, cursor_col, cursor_row, scrolled, input ready);
   modport sink   (input valid, cell_char, cursor_col, cursor_row, scrolled, output ready);
endinterface

### hw/rtl/tcc_ram.sv
`timescale 1ns / 1ps

module tcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/text_console_cursor_scroll_unit.sv
`timescale 1ns / 1ps
// channel     | direction | payload
// req_chan    | in        | mode, char_code, read_row, read_col
// rsp_chan    | out       | cell_char, cursor_col, cursor_row, scrolled
//
// an in-range read or a printable put steps through accept, decode, memory access, result
// a put that scrolls first blanks the new bottom row, one cell a cycle
// the screen store is a ring of rows; scrolling moves the top-row pointer, not the text
// after reset the store is blanked to spaces, all ROWS*COLUMNS cells (2000 by default)
// req_chan.ready is low until then and while an operation is in flight
// a finished result waits in the output register; the next request is taken meanwhile

module text_console_cursor_scroll_unit import tcc_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   tcc_req_if.sink    req_chan,
   tcc_rsp_if.source  rsp_chan
);

   localparam int Cells = ROWS * COLUMNS;
   localparam int AddrW = $clog2(Cells);
   localparam int ColW  = $clog2(COLUMNS + 1);
   localparam int CntW  = $clog2(COLUMNS);
   localparam int RowW  = $clog2(ROWS);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CALC   = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;
   localparam logic [2:0] ST_RWAIT  = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   // control state
   logic [2:0]       state_ff, state_in;
   logic [AddrW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [CntW-1:0]  scr_cnt_ff, scr_cnt_in;
   logic [ColW-1:0]  col_ff, col_in;
   logic [RowW-1:0]  line_ff, line_in;
   logic [RowW-1:0]  top_ff, top_in;
   logic             out_valid_ff, out_valid_in;

   // latched transaction and result
   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic [CHAR_W-1:0]       char_ff, char_in;
   logic [READ_ROW_W-1:0]   rrow_ff, rrow_in;
   logic [READ_COL_W-1:0]   rcol_ff, rcol_in;
   logic [CHAR_W-1:0]       cell_ff, cell_in;
   logic                    scrolled_ff, scrolled_in;
   logic [CHAR_W-1:0]       out_cell_ff, out_cell_in;
   logic [CURSOR_COL_W-1:0] out_col_ff, out_col_in;
   logic [CURSOR_ROW_W-1:0] out_row_ff, out_row_in;
   logic                    out_scr_ff, out_scr_in;

   // memory port
   logic              ram_we;
   logic [AddrW-1:0]  ram_waddr;
   logic [CHAR_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AddrW-1:0]  ram_raddr;
   logic [CHAR_W-1:0] ram_rdata;

   logic req_fire;
   logic out_free;
   logic printable;
   logic wrap;
   logic last_line;
   logic read_ok;

   // logical row to physical row of the ring
   function automatic logic [RowW-1:0] phys_row(input logic [RowW-1:0] r,
                                                input logic [RowW-1:0] top);
      logic [RowW:0] s;
      s = {1'b0, r} + {1'b0, top};
      if (s >= (RowW + 1)'(ROWS)) begin
         s = s - (RowW + 1)'(ROWS);
      end
      return s[RowW-1:0];
   endfunction

   // row and column to store address
   function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0] prow,
                                                  input logic [AddrW-1:0] col);
      return AddrW'(prow) * AddrW'(COLUMNS) + col;
   endfunction

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign printable      = (char_ff != CHAR_NEWLINE) && (char_ff != CHAR_RETURN);
   assign wrap           = (col_ff == ColW'(COLUMNS)) || (char_ff == CHAR_NEWLINE);
   assign last_line      = (line_ff == RowW'(ROWS - 1));
   assign read_ok        = (32'(rrow_ff) < ROWS) && (32'(rcol_ff) < COLUMNS);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      scr_cnt_in   = scr_cnt_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      top_in       = top_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      mode_in      = mode_ff;
      char_in      = char_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      cell_in      = cell_ff;
      scrolled_in  = scrolled_ff;
      out_cell_in  = out_cell_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_scr_in   = out_scr_ff;
      ram_re       = 1'b0;
      ram_raddr    = cell_addr(phys_row(RowW'(rrow_ff), top_ff), AddrW'(rcol_ff));
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AddrW'(1);
            if (clr_cnt_ff == AddrW'(Cells - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               mode_in  = req_chan.mode;
               char_in  = req_chan.char_code;
               rrow_in  = req_chan.read_row;
               rcol_in  = req_chan.read_col;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cell_in     = '0;
            scrolled_in = 1'b0;
            if (mode_ff == MODE_READ) begin
               if (read_ok) begin
                  ram_re   = 1'b1;
                  state_in = ST_RWAIT;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (wrap && last_line) begin
               col_in      = '0;
               scrolled_in = 1'b1;
               scr_cnt_in  = '0;
               state_in    = ST_SCROLL;
            end else begin
               if (wrap) begin
                  col_in  = '0;
                  line_in = line_ff + RowW'(1);
               end
               state_in = printable ? ST_WRITE : ST_FINISH;
            end
         end
         ST_SCROLL: begin
            scr_cnt_in = scr_cnt_ff + CntW'(1);
            if (scr_cnt_ff == CntW'(COLUMNS - 1)) begin
               top_in   = (top_ff == RowW'(ROWS - 1)) ? '0 : top_ff + RowW'(1);
               state_in = printable ? ST_WRITE : ST_FINISH;
            end
         end
         ST_WRITE: begin
            col_in   = col_ff + ColW'(1);
            state_in = ST_FINISH;
         end
         ST_RWAIT: begin
            cell_in  = ram_rdata;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_cell_in  = cell_ff;
               out_col_in   = CURSOR_COL_W'(col_ff);
               out_row_in   = CURSOR_ROW_W'(line_ff);
               out_scr_in   = scrolled_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // store write port: blanking on reset and scroll, characters on put
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_cnt_ff;
      ram_wdata = CHAR_SPACE;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
         end
         ST_SCROLL: begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(top_ff, AddrW'(scr_cnt_ff));
         end
         ST_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(phys_row(line_ff, top_ff), AddrW'(col_ff));
            ram_wdata = char_ff;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         scr_cnt_ff   <= '0;
         col_ff       <= '0;
         line_ff      <= '0;
         top_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         scr_cnt_ff   <= scr_cnt_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         top_ff       <= top_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      char_ff     <= char_in;
      rrow_ff     <= rrow_in;
      rcol_ff     <= rcol_in;
      cell_ff     <= cell_in;
      scrolled_ff <= scrolled_in;
      out_cell_ff <= out_cell_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_scr_ff  <= out_scr_in;
   end

   tcc_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (Cells)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.cell_char  = out_cell_ff;
   assign rsp_chan.cursor_col = out_col_ff;
   assign rsp_chan.cursor_row = out_row_ff;
   assign rsp_chan.scrolled   = out_scr_ff;

endmodule

### bench/text_console_cursor_scroll_unit_tb.sv
`timescale 1ns / 1ps

module text_console_cursor_scroll_unit_tb import tcc_pkg::*; ;

   localparam int COLS         = DEF_COLUMNS;
   localparam int LINES        = DEF_ROWS;
   localparam int RANDOM_ITEMS = 370;
   localparam int PHASE_ITEMS  = 280;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 120;
   localparam int CYCLE_LIMIT  = 500000;

   typedef struct packed {
      logic [MODE_W-1:0]     mode;
      logic [CHAR_W-1:0]     char_code;
      logic [READ_ROW_W-1:0] read_row;
      logic [READ_COL_W-1:0] read_col;
   } console_op_type;

   typedef struct packed {
      logic [CHAR_W-1:0]       cell_char;
      logic [CURSOR_COL_W-1:0] cursor_col;
      logic [CURSOR_ROW_W-1:0] cursor_row;
      logic                    scrolled;
   } console_view_type;

   typedef struct {
      console_op_type   op;
      int               copies;
      bit               given_ok;
      console_view_type given;
   } script_row_type;

   logic clock;
   logic reset;

   tcc_req_if req_chan ();
   tcc_rsp_if rsp_chan ();

   text_console_cursor_scroll_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the console
   logic [CHAR_W-1:0] shadow_screen [LINES][COLS];
   int                shadow_col;
   int                shadow_row;

   console_view_type pending_views [$];
   script_row_type   script_rows [$];

   int  fail_count;
   int  items_sent;
   int  views_checked;
   int  scroll_count;
   int  wrap_count;
   int  read_count;
   int  outside_reads;
   int  tx_idle_pct;
   int  rx_idle_pct;
   bit  rx_hold_req;
   bit  rx_hold;
   int  cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // known values on every input from time zero
   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.mode      = MODE_PUT;
      req_chan.char_code = '0;
      req_chan.read_row  = '0;
      req_chan.read_col  = '0;
      rsp_chan.ready     = 1'b0;
      rx_hold_req        = 1'b0;
      rx_hold            = 1'b0;
      rx_idle_pct        = 78;
   end

   // console behavior: returns the view after one transaction
   function automatic console_view_type predict_console(console_op_type op);
      console_view_type v;
      int r, c;
      v = '0;
      if (op.mode == MODE_READ) begin
         if (op.read_row < LINES && op.read_col < COLS) begin
            v.cell_char = shadow_screen[op.read_row][op.read_col];
         end
      end else begin
         // wrap on a pending column or a newline
         if (shadow_col >= COLS || op.char_code == CHAR_NEWLINE) begin
            shadow_col = 0;
            shadow_row++;
            if (shadow_row >= LINES) begin
               shadow_row = LINES - 1;
               for (r = 0; r < LINES - 1; r++) begin
                  for (c = 0; c < COLS; c++) shadow_screen[r][c] = shadow_screen[r+1][c];
               end
               for (c = 0; c < COLS; c++) shadow_screen[LINES-1][c] = CHAR_SPACE;
               v.scrolled = 1'b1;
            end
         end
         // store printable bytes and advance
         if (op.char_code != CHAR_NEWLINE && op.char_code != CHAR_RETURN) begin
            if (shadow_col < COLS) shadow_screen[shadow_row][shadow_col] = op.char_code;
            shadow_col++;
         end
      end
      v.cursor_col = shadow_col[CURSOR_COL_W-1:0];
      v.cursor_row = shadow_row[CURSOR_ROW_W-1:0];
      return v;
   endfunction

   function automatic console_op_type console_op(logic [MODE_W-1:0] mode,
                                                 logic [CHAR_W-1:0] ch,
                                                 logic [READ_ROW_W-1:0] r,
                                                 logic [READ_COL_W-1:0] c);
      console_op_type op;
      op.mode      = mode;
      op.char_code = ch;
      op.read_row  = r;
      op.read_col  = c;
      return op;
   endfunction

   task automatic add_row(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                          logic [READ_ROW_W-1:0] r, logic [READ_COL_W-1:0] c,
                          int copies, bit given_ok, logic [CHAR_W-1:0] cell_val,
                          logic [CURSOR_COL_W-1:0] col, logic [CURSOR_ROW_W-1:0] row,
                          logic scr);
      script_row_type s;
      s.op       = console_op(mode, ch, r, c);
      s.copies   = copies;
      s.given_ok = given_ok;
      s.given    = {cell_val, col, row, scr};
      script_rows.push_back(s);
   endtask

   // offer one transaction, record the expected view once it is taken
   task automatic send_op(console_op_type op, bit given_ok, console_view_type given);
      console_view_type pred;
      // idling schedule, with a long receiver hold-off when idling stops
      if (items_sent == PHASE_ITEMS) begin
         tx_idle_pct = 78;
         rx_idle_pct <= 37;
      end else if (items_sent == 2 * PHASE_ITEMS) begin
         tx_idle_pct = 0;
         rx_idle_pct <= 0;
         rx_hold_req <= 1'b1;
      end
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.mode      <= op.mode;
      req_chan.char_code <= op.char_code;
      req_chan.read_row  <= op.read_row;
      req_chan.read_col  <= op.read_col;
      do @(posedge clock); while (!(req_chan.valid === 1'b1 && req_chan.ready === 1'b1));
      pred = predict_console(op);
      items_sent++;
      if (op.mode == MODE_READ) begin
         read_count++;
         if (op.read_row >= LINES || op.read_col >= COLS) outside_reads++;
      end
      if (pred.scrolled) scroll_count++;
      if (pred.cursor_col == COLS) wrap_count++;
      pending_views.push_back(given_ok ? given : pred);
   endtask

   // receiver readiness
   always @(posedge clock) begin
      if (rx_hold) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // long receiver hold-off so the block fills and stalls its input
   initial begin
      wait (rx_hold_req);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // result checker
   always @(posedge clock) begin
      console_view_type got, want;
      if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got = {rsp_chan.cell_char, rsp_chan.cursor_col, rsp_chan.cursor_row,
                rsp_chan.scrolled};
         if (pending_views.size() == 0) begin
            $error("unexpected transaction on rsp_chan: %h", got);
            fail_count++;
         end else begin
            want = pending_views.pop_front();
            views_checked++;
            if (got.cell_char !== want.cell_char) begin
               $error("cell_char: expected %0h, actual %0h", want.cell_char, got.cell_char);
               fail_count++;
            end
            if (got.cursor_col !== want.cursor_col) begin
               $error("cursor_col: expected %0d, actual %0d", want.cursor_col,
                      got.cursor_col);
               fail_count++;
            end
            if (got.cursor_row !== want.cursor_row) begin
               $error("cursor_row: expected %0d, actual %0d", want.cursor_row,
                      got.cursor_row);
               fail_count++;
            end
            if (got.scrolled !== want.scrolled) begin
               $error("scrolled: expected %0d, actual %0d", want.scrolled, got.scrolled);
               fail_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
   end

   // stimulus
   initial begin
      int             k, n, pick, target;
      logic [7:0]     ch;
      script_row_type s;

      fail_count    = 0;
      items_sent    = 0;
      views_checked = 0;
      scroll_count  = 0;
      wrap_count    = 0;
      read_count    = 0;
      outside_reads = 0;
      tx_idle_pct   = 37;
      shadow_col    = 0;
      shadow_row    = 0;
      for (int r = 0; r < LINES; r++) begin
         for (int c = 0; c < COLS; c++) shadow_screen[r][c] = CHAR_SPACE;
      end

      // directed script: reset contents, extremes, returns, newlines, wraps, scrolls
      add_row(MODE_READ, 8'h00, 0,  0,   1, 1, CHAR_SPACE, 0,  0,  0);
      add_row(MODE_READ, 8'hFF, 24, 79,  1, 1, CHAR_SPACE, 0,  0,  0);
      add_row(MODE_READ, 8'h00, 25, 0,   1, 1, 8'h00,      0,  0,  0);
      add_row(MODE_READ, 8'h00, 31, 127, 1, 1, 8'h00,      0,  0,  0);
      add_row(MODE_READ, 8'h00, 0,  80,  1, 1, 8'h00,      0,  0,  0);
      add_row(MODE_PUT,  8'h41, 0,  0,   1, 1, 8'h00,      1,  0,  0);
      add_row(MODE_PUT,  8'hFF, 31, 127, 1, 1, 8'h00,      2,  0,  0);
      add_row(MODE_PUT,  8'h00, 0,  0,   1, 1, 8'h00,      3,  0,  0);
      add_row(MODE_READ, 8'h00, 0,  0,   1, 1, 8'h41,      3,  0,  0);
      add_row(MODE_READ, 8'h00, 0,  1,   1, 1, 8'hFF,      3,  0,  0);
      add_row(MODE_PUT,  CHAR_RETURN,  0, 0, 1, 1, 8'h00,  3,  0,  0);
      add_row(MODE_PUT,  CHAR_NEWLINE, 0, 0, 1, 1, 8'h00,  0,  1,  0);
      // fill a line to a pending wrap, then a return only performs the wrap
      add_row(MODE_PUT,  8'h78, 0,  0,   COLS, 0, 0, 0, 0, 0);
      add_row(MODE_READ, 8'h00, 1,  79,  1, 1, 8'h78,      80, 1,  0);
      add_row(MODE_PUT,  CHAR_RETURN,  0, 0, 1, 1, 8'h00,  0,  2,  0);
      // a newline on a pending wrap advances one line only
      add_row(MODE_PUT,  8'h79, 0,  0,   COLS, 0, 0, 0, 0, 0);
      add_row(MODE_PUT,  CHAR_NEWLINE, 0, 0, 1, 1, 8'h00,  0,  3,  0);
      add_row(MODE_READ, 8'h00, 2,  0,   1, 1, 8'h79,      0,  3,  0);
      // run down to the last row and scroll by newline
      add_row(MODE_PUT,  CHAR_NEWLINE, 0, 0, 21, 0, 0, 0, 0, 0);
      add_row(MODE_PUT,  8'h7A, 0,  0,   1, 1, 8'h00,      1,  24, 0);
      add_row(MODE_PUT,  CHAR_NEWLINE, 0, 0, 1, 1, 8'h00,  0,  24, 1);
      add_row(MODE_READ, 8'h00, 23, 0,   1, 1, 8'h7A,      0,  24, 0);
      add_row(MODE_READ, 8'h00, 1,  0,   1, 1, 8'h79,      0,  24, 0);
      // scroll by wrap on the last row
      add_row(MODE_PUT,  8'h77, 0,  0,   COLS, 0, 0, 0, 0, 0);
      add_row(MODE_PUT,  8'h76, 0,  0,   1, 1, 8'h00,      1,  24, 1);
      add_row(MODE_READ, 8'h00, 23, 79,  1, 1, 8'h77,      1,  24, 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (script_rows[i]) begin
         s = script_rows[i];
         for (k = 0; k < s.copies; k++) send_op(s.op, s.given_ok, s.given);
      end

      // random text: lines of varied length, reads, line breaks and noise
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            k = $urandom_range(99);
            n = (k < 60) ? $urandom_range(0, 10) :
                (k < 85) ? $urandom_range(11, 40) : $urandom_range(70, 90);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(99) < 8)
                  send_op(console_op(MODE_READ, CHAR_W'($urandom_range(0, 255)),
                                     READ_ROW_W'(shadow_row),
                                     READ_COL_W'($urandom_range(0, COLS - 1))), 0, '0);
               ch = CHAR_W'($urandom_range(0, 255));
               if (ch == CHAR_NEWLINE || ch == CHAR_RETURN) ch = CHAR_SPACE;
               send_op(console_op(MODE_PUT, ch, READ_ROW_W'($urandom_range(0, 31)),
                                  READ_COL_W'($urandom_range(0, 127))), 0, '0);
            end
            if ($urandom_range(99) < 75)
               send_op(console_op(MODE_PUT, CHAR_NEWLINE, 0, 0), 0, '0);
         end else if (pick < 65) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(99) < 15)
                  send_op(console_op(MODE_READ, CHAR_W'($urandom_range(0, 255)),
                                     READ_ROW_W'($urandom_range(0, 31)),
                                     READ_COL_W'($urandom_range(0, 127))), 0, '0);
               else
                  send_op(console_op(MODE_READ, CHAR_W'($urandom_range(0, 255)),
                                     READ_ROW_W'($urandom_range(0, LINES - 1)),
                                     READ_COL_W'($urandom_range(0, COLS - 1))), 0, '0);
            end
         end else if (pick < 85) begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
               ch = ($urandom_range(99) < 70) ? CHAR_NEWLINE : CHAR_RETURN;
               send_op(console_op(MODE_PUT, ch, READ_ROW_W'($urandom_range(0, 31)),
                                  READ_COL_W'($urandom_range(0, 127))), 0, '0);
            end
         end else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
               send_op(console_op(MODE_W'($urandom_range(0, 1)),
                                  CHAR_W'($urandom_range(0, 255)),
                                  READ_ROW_W'($urandom_range(0, 31)),
                                  READ_COL_W'($urandom_range(0, 127))), 0, '0);
         end
      end
      req_chan.valid <= 1'b0;

      // drain
      while (pending_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d transactions checked: %0d scrolls, %0d pending wraps,",
               views_checked, scroll_count, wrap_count);
      $display("%0d cell reads of which %0d fell outside the screen",
               read_count, outside_reads);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_if.sv
hw/rtl/tcc_ram.sv
hw/rtl/text_console_cursor_scroll_unit.sv
bench/text_console_cursor_scroll_unit_tb.sv
